// ----- rtl/rvs_pkg.sv -----
// Shared constants, codes and control structs for the RRIP victim selection core.
// No dependencies; imported by every module of the block except the generic RAM.
package rvs_pkg;

   localparam int WAYS        = 16;
   localparam int SETS        = 64;
   localparam int RRPV_W      = 3;
   localparam int RRPV_LEVELS = 1 << RRPV_W;
   localparam int WAY_W       = $clog2(WAYS);
   localparam int SET_W       = $clog2(SETS);
   localparam int ROW_W       = WAYS * RRPV_W;

   // Port widths fixed by the interface
   localparam int CMD_W       = 2;
   localparam int SET_IDX_W   = 6;
   localparam int WAY_IDX_W   = 4;
   localparam int MASK_W      = 16;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 3;

   localparam logic [RRPV_W-1:0] MAX_RRPV_RESET    = 3'd7;
   localparam logic [RRPV_W-1:0] INSERT_RRPV_RESET = 3'd6;

   typedef enum logic [CMD_W-1:0] {
      CMD_HIT    = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_EVICT  = 2'd2
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_RRPV    = 1'b0,
      CSR_INSERT_RRPV = 1'b1
   } csr_index_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   typedef logic [WAYS-1:0][RRPV_W-1:0] row_type;

   typedef struct packed {
      logic capture;   // latch request, launch row read
      logic wr_row;    // write updated row back
      logic load_rsp;  // load response register
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_evict;  // captured request is an evict
      logic do_write;  // captured request changes the row
   } dp_status_type;

endpackage

// ----- rtl/rvs_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module rvs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/rvs_ctrl.sv -----
// Controller FSM: request/response handshake and sequencing of the datapath.
// Depends on rvs_pkg.
module rvs_ctrl
   import rvs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      stall;

   // an evict must wait while an older response is still held
   assign stall = status.is_evict && rsp_valid_ff && !rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (!stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_EXEC: begin
            cmd.wr_row   = !stall && status.do_write;
            cmd.load_rsp = !stall && status.is_evict;
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/rvs_datapath.sv -----
// Datapath: request latch, config registers, RRPV row RAM with per-row valid bits,
// victim search, aging and the response register. Depends on rvs_pkg, rvs_ram.
module rvs_datapath
   import rvs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [CMD_W-1:0]      req_command,
   input  logic [SET_IDX_W-1:0]  req_set_index,
   input  logic [WAY_IDX_W-1:0]  req_way_index,
   input  logic [MASK_W-1:0]     req_valid_mask,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   input  ctrl_cmd_type          cmd,
   output dp_status_type         status,
   output logic [WAY_IDX_W-1:0]  rsp_victim_way,
   output logic                  rsp_victim_was_invalid
);

   logic [CMD_W-1:0]     cmd_ff;
   logic [SET_W-1:0]     set_ff;
   logic [WAY_IDX_W-1:0] way_ff;
   logic [MASK_W-1:0]    mask_ff;
   logic [RRPV_W-1:0]    max_rrpv_ff, insert_rrpv_ff;
   logic [SETS-1:0]      row_valid_ff;
   logic                 row_live_ff;
   logic [WAY_IDX_W-1:0] victim_way_ff, victim_way_in;
   logic                 victim_inv_ff;

   logic [SET_W-1:0]     rd_set;
   logic [ROW_W-1:0]     rd_data;
   row_type              row, new_row;
   logic                 way_ok;
   logic                 inv_found;
   logic [WAY_W-1:0]     inv_way;
   logic [RRPV_LEVELS-1:0] present;
   logic [RRPV_W-1:0]    top;
   logic [WAY_W-1:0]     victim;

   // SETS is a power of two: the modulo is the low bits
   assign rd_set = req_set_index[SET_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff      <= req_command;
         set_ff      <= rd_set;
         way_ff      <= req_way_index;
         mask_ff     <= req_valid_mask;
         row_live_ff <= row_valid_ff[rd_set];
      end
      if (cmd.load_rsp) begin
         victim_way_ff <= victim_way_in;
         victim_inv_ff <= inv_found;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_rrpv_ff    <= MAX_RRPV_RESET;
         insert_rrpv_ff <= INSERT_RRPV_RESET;
         row_valid_ff   <= '0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_MAX_RRPV:    max_rrpv_ff    <= csr_wr_data[RRPV_W-1:0];
               CSR_INSERT_RRPV: insert_rrpv_ff <= csr_wr_data[RRPV_W-1:0];
               default: ;
            endcase
         end
         if (cmd.wr_row) row_valid_ff[set_ff] <= 1'b1;
      end
   end

   rvs_ram #(
      .WIDTH (ROW_W),
      .DEPTH (SETS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_row),
      .wr_addr (set_ff),
      .wr_data (ROW_W'(new_row)),
      .rd_en   (cmd.capture),
      .rd_addr (rd_set),
      .rd_data (rd_data)
   );

   // never-written rows read as all zero
   assign row = row_live_ff ? row_type'(rd_data) : '0;

   assign way_ok = 32'(way_ff) < WAYS;

   // lowest empty way
   always_comb begin
      inv_found = 1'b0;
      inv_way   = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (!mask_ff[w]) begin
            inv_found = 1'b1;
            inv_way   = WAY_W'(w);
         end
      end
   end

   // largest value via per-level presence, then lowest way at that level
   always_comb begin
      present = '0;
      for (int w = 0; w < WAYS; w++) begin
         present[row[w]] = 1'b1;
      end
      top = '0;
      for (int v = 0; v < RRPV_LEVELS; v++) begin
         if (present[v]) top = RRPV_W'(v);
      end
      victim = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (row[w] == top) victim = WAY_W'(w);
      end
   end

   always_comb begin
      new_row = row;
      case (cmd_ff)
         CMD_HIT: begin
            if (way_ok) new_row[way_ff[WAY_W-1:0]] = '0;
         end
         CMD_INSERT: begin
            if (way_ok) new_row[way_ff[WAY_W-1:0]] = insert_rrpv_ff;
         end
         CMD_EVICT: begin
            for (int w = 0; w < WAYS; w++) begin
               if (WAY_W'(w) != victim && row[w] < max_rrpv_ff) begin
                  new_row[w] = row[w] + RRPV_W'(1);
               end
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      status.is_evict = (cmd_ff == CMD_EVICT);
      case (cmd_ff)
         CMD_HIT, CMD_INSERT: status.do_write = way_ok;
         CMD_EVICT:           status.do_write = !inv_found;
         default:             status.do_write = 1'b0;
      endcase
   end

   assign victim_way_in          = WAY_IDX_W'(inv_found ? inv_way : victim);
   assign rsp_victim_way         = victim_way_ff;
   assign rsp_victim_was_invalid = victim_inv_ff;

endmodule

// ----- rtl/rrip_victim_selection_core.sv -----
// RRIP victim selection core: one 3-bit RRPV per way per set, SRRIP aging on evict.
// Latency: the set row is read at the edge that accepts a request; an evict has its
// response valid after the next edge, later only while an older response is held.
// A new request is taken only after the previous one's row write-back step is done.
// Reset (synchronous): max_rrpv 7, insert_rrpv 6, all rows read as zero through
// per-row valid bits cleared at once; no clearing pass. Depends on rvs_pkg and modules.
module rrip_victim_selection_core
   import rvs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [CMD_W-1:0]      req_command,
   input  logic [SET_IDX_W-1:0]  req_set_index,
   input  logic [WAY_IDX_W-1:0]  req_way_index,
   input  logic [MASK_W-1:0]     req_valid_mask,
   // response channel, evict only
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [WAY_IDX_W-1:0]  rsp_victim_way,
   output logic                  rsp_victim_was_invalid,
   // config write port
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Controller: accepts a request in idle, then moves to the execute state for the
   // write-back; an evict holds there while an old response is not taken.
   rvs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: row RAM, victim search, aging and response register.
   rvs_datapath u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .req_command            (req_command),
      .req_set_index          (req_set_index),
      .req_way_index          (req_way_index),
      .req_valid_mask         (req_valid_mask),
      .csr_wr_en              (csr_wr_en),
      .csr_index              (csr_index),
      .csr_wr_data            (csr_wr_data),
      .cmd                    (cmd),
      .status                 (status),
      .rsp_victim_way         (rsp_victim_way),
      .rsp_victim_was_invalid (rsp_victim_was_invalid)
   );

endmodule
